// ===== rtl/lirs_pkg.sv =====
// ----------------------------------------------------------------------------
// lirs_pkg
// Types and constants shared by the linear interpolation resampler: payload
// structs, sequencer states, unit control structs and fixed-point widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

  // sample and phase formats
  localparam int SAMPLE_BITS = 24;
  localparam int PH_FRAC     = 24;
  localparam int PH_BITS     = 28;
  localparam int PCM_BITS    = 16;
  localparam int PCM_GUARD   = PCM_BITS - 1;

  // datapath widths
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int MULT_W = 2 * DIFF_W;
  localparam int X_W    = MULT_W;
  localparam int V_W    = X_W + 1;
  localparam int F_BITS = SAMPLE_BITS + PH_FRAC;
  localparam int MAG_W  = F_BITS + 1;
  localparam int SCL_W  = MAG_W + PCM_GUARD;

  // phase and ratio constants, Q4.24
  localparam logic [PH_BITS-1:0] PH_ONE      = 28'h100_0000;
  localparam logic [PH_BITS-1:0] RATIO_MIN   = 28'd262144;
  localparam logic [PH_BITS-1:0] RATIO_MAX   = 28'd134217728;
  localparam logic [PH_BITS-1:0] RATIO_RESET = 28'h100_0000;

  // full scale and rounding half point of the interpolated value
  localparam logic [MAG_W-1:0]  MAG_FULL = {1'b1, {F_BITS{1'b0}}};
  localparam logic [F_BITS-1:0] RND_HALF = {1'b1, {(F_BITS-1){1'b0}}};

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_RATE_RATIO = 1'b0;
  localparam logic [0:0] REG_MONO_MODE  = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [PCM_BITS-1:0] left_out;
    logic signed [PCM_BITS-1:0] right_out;
    logic                       last_of_run;
  } out_t;

  typedef struct packed {
    logic mul;
    logic acc;
  } mac_ctl_t;

  typedef struct packed {
    logic load;
    logic mag;
    logic scale;
    logic round;
  } pcm_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_L,
    ST_ACC_L,
    ST_MUL_R,
    ST_ACC_R,
    ST_LD_L,
    ST_MAG_L,
    ST_SCL_L,
    ST_RND_L,
    ST_LD_R,
    ST_MAG_R,
    ST_SCL_R,
    ST_RND_R,
    ST_OUT
  } st_e;

endpackage

`default_nettype wire

// ===== rtl/lirs_mac.sv =====
// ----------------------------------------------------------------------------
// lirs_mac
// Shared interpolation unit: one step multiplies the sample difference by the
// phase fraction, the next step adds the scaled earlier sample.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_mac (
  input  wire                                      clk_i,
  input  wire lirs_pkg::mac_ctl_t                  ctl_i,
  input  wire logic signed [lirs_pkg::SAMPLE_BITS-1:0] a_i,
  input  wire logic signed [lirs_pkg::SAMPLE_BITS-1:0] b_i,
  input  wire logic [lirs_pkg::PH_FRAC-1:0]        frac_i,
  output logic signed [lirs_pkg::X_W-1:0]          x_o
);

  logic signed [lirs_pkg::DIFF_W-1:0] diff;
  logic signed [lirs_pkg::DIFF_W-1:0] frac_s;
  logic signed [lirs_pkg::MULT_W-1:0] prod_d, prod_q;
  logic signed [lirs_pkg::X_W-1:0]    base;
  logic signed [lirs_pkg::X_W-1:0]    x_d, x_q;

  // difference times fraction
  assign diff   = $signed({b_i[lirs_pkg::SAMPLE_BITS-1], b_i})
                - $signed({a_i[lirs_pkg::SAMPLE_BITS-1], a_i});
  assign frac_s = $signed({1'b0, frac_i});
  assign prod_d = diff * frac_s;

  // earlier sample scaled to the phase grid plus product
  assign base = $signed({{(lirs_pkg::X_W-lirs_pkg::SAMPLE_BITS){a_i[lirs_pkg::SAMPLE_BITS-1]}},
                         a_i}) <<< lirs_pkg::PH_FRAC;
  assign x_d  = base + prod_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctl_i.acc) begin
      x_q <= x_d;
    end
  end

  assign x_o = x_q;

endmodule

`default_nettype wire

// ===== rtl/lirs_pcm.sv =====
// ----------------------------------------------------------------------------
// lirs_pcm
// PCM conversion unit: clamps the interpolated value to full scale, scales it
// by 32767 with a shift and subtract, and rounds half to even, one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_pcm (
  input  wire                                  clk_i,
  input  wire lirs_pkg::pcm_ctl_t              ctl_i,
  input  wire logic signed [lirs_pkg::V_W-1:0] v_i,
  output logic signed [lirs_pkg::PCM_BITS-1:0] pcm_o
);

  logic signed [lirs_pkg::V_W-1:0]    v_q;
  logic [lirs_pkg::V_W-1:0]           abs_v;
  logic [lirs_pkg::MAG_W-1:0]         mag_d, mag_q;
  logic                               neg_q;
  logic [lirs_pkg::SCL_W-1:0]         scl_d, scl_q;
  logic [lirs_pkg::PCM_BITS-1:0]      quo;
  logic [lirs_pkg::F_BITS-1:0]        rem;
  logic                               rnd_up;
  logic [lirs_pkg::PCM_BITS-1:0]      quo_r;
  logic signed [lirs_pkg::PCM_BITS-1:0] res_d, res_q;

  // magnitude, clamped to full scale
  assign abs_v = v_q[lirs_pkg::V_W-1] ? (-v_q) : v_q;
  assign mag_d = (abs_v > {{(lirs_pkg::V_W-lirs_pkg::MAG_W){1'b0}}, lirs_pkg::MAG_FULL})
               ? lirs_pkg::MAG_FULL : abs_v[lirs_pkg::MAG_W-1:0];

  // times 32767
  assign scl_d = {mag_q, {lirs_pkg::PCM_GUARD{1'b0}}}
               - {{lirs_pkg::PCM_GUARD{1'b0}}, mag_q};

  // round half to even and restore sign
  assign quo    = scl_q[lirs_pkg::SCL_W-1:lirs_pkg::F_BITS];
  assign rem    = scl_q[lirs_pkg::F_BITS-1:0];
  assign rnd_up = (rem > lirs_pkg::RND_HALF) || ((rem == lirs_pkg::RND_HALF) && quo[0]);
  assign quo_r  = quo + {{(lirs_pkg::PCM_BITS-1){1'b0}}, rnd_up};
  assign res_d  = neg_q ? $signed(-quo_r) : $signed(quo_r);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      v_q <= v_i;
    end
    if (ctl_i.mag) begin
      neg_q <= v_q[lirs_pkg::V_W-1];
      mag_q <= mag_d;
    end
    if (ctl_i.scale) begin
      scl_q <= scl_d;
    end
    if (ctl_i.round) begin
      res_q <= res_d;
    end
  end

  assign pcm_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/linear_interp_resampler_pcm16_top.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_pcm16_top
// Stereo sample rate converter by linear interpolation with 16-bit PCM output.
// ----------------------------------------------------------------------------
// Usage:
//   Source samples arrive on the in channel (in_valid_i / in_stall_o), one
//   stereo Q0.23 pair per request. Each request yields a run of zero or more
//   PCM frames on the out channel (out_valid_o / out_stall_i); last_of_run
//   marks the final frame of a run. The first request of a stream only fills
//   the history and gives no frames.
//   rate_ratio (Q4.24, clamped to 1/64..8 on write) and mono_mode are set over
//   the APB port, by the user only while the block is idle; the block itself does not enforce it.
// Sequence:
//   After a request is taken, a check state tests the phase, then each frame
//   passes in turn through the shared interpolation unit (left multiply and
//   accumulate, then right), the conversion unit (load, magnitude, scale and
//   round for left, then right) and the output state. The input is stalled
//   from the check state until the sequencer is idle again.
// Reset and stall:
//   Reset clears the history, phase and output valid flag. A stalled output
//   frame is held in the output register while the next frame is computed;
//   the sequencer waits only when a second frame is ready and the first is
//   still held.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler_pcm16_top #(
  parameter int MAX_RUN = 64
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // input channel
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire lirs_pkg::in_t                   in_data_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output lirs_pkg::out_t                       out_data_o,
  // configuration port
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire logic [lirs_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lirs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lirs_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int RUN_W = $clog2(MAX_RUN);

  lirs_pkg::st_e state_q, state_d;

  // configuration registers
  logic [lirs_pkg::PH_BITS-1:0] rate_q;
  logic [lirs_pkg::PH_BITS-1:0] ratio_eff_q;
  logic [lirs_pkg::PH_BITS-1:0] wr_rate;
  logic [lirs_pkg::PH_BITS-1:0] wr_ratio_eff;
  logic                         mono_q;
  logic                         cfg_wr;

  // stream state
  logic signed [lirs_pkg::SAMPLE_BITS-1:0] prev_l_q, prev_r_q, next_l_q, next_r_q;
  logic [lirs_pkg::PH_BITS-1:0]            phase_q;
  logic [1:0]                              primed_q;
  logic [RUN_W-1:0]                        run_q;

  // datapath
  lirs_pkg::mac_ctl_t                      mac_ctl;
  lirs_pkg::pcm_ctl_t                      pcm_ctl;
  logic                                    sel_right;
  logic signed [lirs_pkg::SAMPLE_BITS-1:0] mac_a, mac_b;
  logic signed [lirs_pkg::X_W-1:0]         mac_x;
  logic signed [lirs_pkg::X_W-1:0]         xl_q;
  logic signed [lirs_pkg::V_W-1:0]         v_sum, v_dbl_l, v_dbl_r, v_in;
  logic signed [lirs_pkg::PCM_BITS-1:0]    pcm_res;
  logic signed [lirs_pkg::PCM_BITS-1:0]    left_pcm_q;

  // frame emission
  logic                                    in_acc;
  logic                                    out_load;
  logic [lirs_pkg::PH_BITS-1:0]            phase_nxt;
  logic                                    run_last;
  logic                                    out_valid_q;
  lirs_pkg::out_t                          out_q;

  // config write decode and ratio clamp
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign wr_rate      = pwdata[lirs_pkg::PH_BITS-1:0];
  assign wr_ratio_eff = (wr_rate < lirs_pkg::RATIO_MIN) ? lirs_pkg::RATIO_MIN
                      : (wr_rate > lirs_pkg::RATIO_MAX) ? lirs_pkg::RATIO_MAX : wr_rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= lirs_pkg::RATIO_RESET;
      ratio_eff_q <= lirs_pkg::RATIO_RESET;
      mono_q      <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        lirs_pkg::REG_RATE_RATIO: begin
          rate_q      <= wr_rate;
          ratio_eff_q <= wr_ratio_eff;
        end
        lirs_pkg::REG_MONO_MODE: begin
          mono_q <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      lirs_pkg::REG_RATE_RATIO:
        prdata = {{(lirs_pkg::APB_DATA_W-lirs_pkg::PH_BITS){1'b0}}, rate_q};
      lirs_pkg::REG_MONO_MODE:
        prdata = {{(lirs_pkg::APB_DATA_W-1){1'b0}}, mono_q};
      default:
        prdata = '0;
    endcase
  end

  // handshakes
  assign in_stall_o = (state_q != lirs_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == lirs_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);
  assign phase_nxt  = phase_q + ratio_eff_q;
  assign run_last   = (phase_nxt >= lirs_pkg::PH_ONE)
                   || (run_q == RUN_W'(MAX_RUN - 1));

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lirs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and unit controls
  always_comb begin
    state_d   = state_q;
    mac_ctl   = '0;
    pcm_ctl   = '0;
    sel_right = 1'b0;
    case (state_q)
      lirs_pkg::ST_IDLE: begin
        if (in_acc && (primed_q != 2'd0)) begin
          state_d = lirs_pkg::ST_CHECK;
        end
      end
      lirs_pkg::ST_CHECK: begin
        state_d = (phase_q < lirs_pkg::PH_ONE) ? lirs_pkg::ST_MUL_L : lirs_pkg::ST_IDLE;
      end
      lirs_pkg::ST_MUL_L: begin
        mac_ctl.mul = 1'b1;
        state_d     = lirs_pkg::ST_ACC_L;
      end
      lirs_pkg::ST_ACC_L: begin
        mac_ctl.acc = 1'b1;
        state_d     = lirs_pkg::ST_MUL_R;
      end
      lirs_pkg::ST_MUL_R: begin
        sel_right   = 1'b1;
        mac_ctl.mul = 1'b1;
        state_d     = lirs_pkg::ST_ACC_R;
      end
      lirs_pkg::ST_ACC_R: begin
        sel_right   = 1'b1;
        mac_ctl.acc = 1'b1;
        state_d     = lirs_pkg::ST_LD_L;
      end
      lirs_pkg::ST_LD_L: begin
        pcm_ctl.load = 1'b1;
        state_d      = lirs_pkg::ST_MAG_L;
      end
      lirs_pkg::ST_MAG_L: begin
        pcm_ctl.mag = 1'b1;
        state_d     = lirs_pkg::ST_SCL_L;
      end
      lirs_pkg::ST_SCL_L: begin
        pcm_ctl.scale = 1'b1;
        state_d       = lirs_pkg::ST_RND_L;
      end
      lirs_pkg::ST_RND_L: begin
        pcm_ctl.round = 1'b1;
        state_d       = lirs_pkg::ST_LD_R;
      end
      lirs_pkg::ST_LD_R: begin
        sel_right    = 1'b1;
        pcm_ctl.load = 1'b1;
        state_d      = lirs_pkg::ST_MAG_R;
      end
      lirs_pkg::ST_MAG_R: begin
        pcm_ctl.mag = 1'b1;
        state_d     = lirs_pkg::ST_SCL_R;
      end
      lirs_pkg::ST_SCL_R: begin
        pcm_ctl.scale = 1'b1;
        state_d       = lirs_pkg::ST_RND_R;
      end
      lirs_pkg::ST_RND_R: begin
        pcm_ctl.round = 1'b1;
        state_d       = lirs_pkg::ST_OUT;
      end
      lirs_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = run_last ? lirs_pkg::ST_IDLE : lirs_pkg::ST_MUL_L;
        end
      end
      default: begin
        state_d = lirs_pkg::ST_IDLE;
      end
    endcase
  end

  // sample history, phase and run count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q <= '0;
      prev_r_q <= '0;
      next_l_q <= '0;
      next_r_q <= '0;
      phase_q  <= '0;
      primed_q <= 2'd0;
      run_q    <= '0;
    end else if (in_acc) begin
      run_q <= '0;
      case (primed_q)
        2'd0: begin
          prev_l_q <= in_data_i.left_in;
          prev_r_q <= in_data_i.right_in;
          primed_q <= 2'd1;
        end
        2'd1: begin
          next_l_q <= in_data_i.left_in;
          next_r_q <= in_data_i.right_in;
          primed_q <= 2'd2;
        end
        default: begin
          prev_l_q <= next_l_q;
          prev_r_q <= next_r_q;
          next_l_q <= in_data_i.left_in;
          next_r_q <= in_data_i.right_in;
          phase_q  <= (phase_q >= lirs_pkg::PH_ONE) ? (phase_q - lirs_pkg::PH_ONE) : '0;
        end
      endcase
    end else if (out_load) begin
      run_q <= run_q + 1'b1;
      if (run_last && (phase_nxt < lirs_pkg::PH_ONE)) begin
        phase_q <= lirs_pkg::PH_ONE;
      end else begin
        phase_q <= phase_nxt;
      end
    end
  end

  // interpolation unit operands
  assign mac_a = sel_right ? prev_r_q : prev_l_q;
  assign mac_b = sel_right ? next_r_q : next_l_q;

  lirs_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .frac_i (phase_q[lirs_pkg::PH_FRAC-1:0]),
    .x_o    (mac_x)
  );

  // conversion input: channel doubled, or left plus right in mono
  assign v_sum   = $signed({xl_q[lirs_pkg::X_W-1], xl_q})
                 + $signed({mac_x[lirs_pkg::X_W-1], mac_x});
  assign v_dbl_l = $signed({xl_q, 1'b0});
  assign v_dbl_r = $signed({mac_x, 1'b0});
  assign v_in    = mono_q ? v_sum : (sel_right ? v_dbl_r : v_dbl_l);

  lirs_pcm u_pcm (
    .clk_i (clk_i),
    .ctl_i (pcm_ctl),
    .v_i   (v_in),
    .pcm_o (pcm_res)
  );

  // hold left interpolation and left pcm while the right side is worked
  always_ff @(posedge clk_i) begin
    if (state_q == lirs_pkg::ST_MUL_R) begin
      xl_q <= mac_x;
    end
    if (state_q == lirs_pkg::ST_LD_R) begin
      left_pcm_q <= pcm_res;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.left_out    <= left_pcm_q;
      out_q.right_out   <= pcm_res;
      out_q.last_of_run <= run_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
